/* hdl/lsvm_pkg.sv */
// Shared types and constants for the linear SVM decision engine.
// No dependencies; imported by the top level, the score unit and the bench.
package lsvm_pkg;

  // Request opcodes carried on the func field
  localparam logic [1:0] FUNC_SET_W   = 2'd0;  // weight = coefficient * value
  localparam logic [1:0] FUNC_ADD_W   = 2'd1;  // weight += coefficient * value, saturating
  localparam logic [1:0] FUNC_FEATURE = 2'd2;  // sum += value * weight

  typedef logic signed [31:0] weight_t;   // Q12.20
  typedef logic signed [47:0] mprod_t;    // Q16.32, exact feature product
  typedef logic signed [63:0] sum_t;      // Q32.32 running sum
  typedef logic signed [31:0] score_t;    // Q16.16

  localparam weight_t W_MAX   = 32'sh7FFF_FFFF;
  localparam weight_t W_MIN   = 32'sh8000_0000;
  localparam sum_t    SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam sum_t    SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam sum_t    SUM_LIM = 64'sh4000_0000_0000_0000;   // clamp bound 2^62

endpackage

/* hdl/lsvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsvm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lsvm_score.sv */
// Score formation: clamp the running sum, add the widened bias, round, saturate.
// Depends on lsvm_pkg.
module lsvm_score
  import lsvm_pkg::*;
(
  input  sum_t              sum,
  input  logic signed [31:0] bias,
  output score_t            score
);

  sum_t              s_cl;
  logic signed [64:0] t;

  always_comb begin
    if (sum > SUM_LIM) begin
      s_cl = SUM_LIM;
    end else if (sum < -SUM_LIM) begin
      s_cl = -SUM_LIM;
    end else begin
      s_cl = sum;
    end
    // bias to Q16.32, plus half an LSB of the result for round half up
    t = {s_cl[63], s_cl} + {{17{bias[31]}}, bias, 16'd0} + 65'sd32768;
    if (t >= 65'sh8000_0000_0000) begin
      score = 32'sh7FFF_FFFF;
    end else if (t < -65'sh8000_0000_0000) begin
      score = 32'sh8000_0000;
    end else begin
      score = t[47:16];
    end
  end

endmodule

/* hdl/linear_svm_decision_engine_top.sv */
// Linear SVM decision engine: weight store build-up and streaming dot-product scoring.
// Depends on lsvm_pkg, lsvm_ram (weight store) and lsvm_score (score formation).
//
//  channel  | signals                                       | direction
//  ---------+-----------------------------------------------+----------
//  request  | in_valid, in_stall, func, index, value,       | in
//           | coefficient, last                             |
//  result   | out_valid, out_stall, score                   | out
//  config   | cfg_we, cfg_data (bias, signed Q16.16)        | in
//
// One request per cycle, sustained while in_stall is low, any mix of weight writes and feature elements.
// After its last feature element, a score passes stages B, C and D into the output register.
// The weight store is a one-read, one-write RAM: read at acceptance, modified and
// written back in stage B; a back-to-back request on the same entry takes the
// fresh weight from a forwarding register.
// Reset (synchronous) clears the bias, the running sum and the per-entry valid bits;
// an entry never written reads as zero, so no clearing pass runs.
// in_stall rises only while a score waits in the skid stage behind a stalled output.
module linear_svm_decision_engine_top
  import lsvm_pkg::*;
#(
  parameter int FEATURES = 256
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         index,
  input  logic signed [15:0] value,
  input  logic signed [15:0] coefficient,
  input  logic               last,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] score,
  // bias register
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data
);

  // Only indexes 0..255 can be addressed, so the store never needs more entries.
  localparam int DEPTH  = (FEATURES > 256) ? 256 : FEATURES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] bias;

  // pipeline advance: freeze everything while the skid stage is occupied
  logic adv;
  logic in_take;
  logic in_inside;
  logic [ADDR_W-1:0] in_addr;

  // weight store and its valid bits
  logic [DEPTH-1:0]  wvalid;
  logic              vbit_q;
  logic              ram_we;
  weight_t           ram_rdata;

  // stage B: read data back, read-modify-write of the weight
  logic              b_valid;
  logic [1:0]        b_func;
  logic [ADDR_W-1:0] b_addr;
  logic              b_inside;
  logic signed [15:0] b_val;
  logic              b_last;
  weight_t           b_pcv;      // coefficient * value, formed at acceptance
  weight_t           b_w;
  weight_t           b_new_w;
  logic signed [32:0] b_wsum;
  mprod_t            b_mp;
  logic              b_feat;

  // forwarding of the previous write-back
  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  weight_t           fw_data;

  // stage C: accumulate
  logic              c_valid;
  logic              c_last;
  mprod_t            c_mp;
  sum_t              acc;
  sum_t              acc_next;
  logic signed [64:0] c_sum;

  // stage D: score formation
  logic              d_valid;
  sum_t              d_sum;
  score_t            d_score;

  // output register and skid stage
  logic              skid_valid;
  score_t            skid_score;
  logic              out_take;
  logic              res_fire;

  assign adv       = !skid_valid;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && adv;
  assign in_inside = ({24'd0, index} < 32'(FEATURES));
  assign in_addr   = index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_we) begin
      bias <= cfg_data;
    end
  end

  // ---------------- stage A -> B: capture request, issue the weight read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_func   <= func;
      b_addr   <= in_addr;
      b_inside <= in_inside;
      b_val    <= value;
      b_last   <= last;
      b_pcv    <= weight_t'(value) * weight_t'(coefficient);
      vbit_q   <= in_inside ? wvalid[in_addr] : 1'b0;
    end
  end

  lsvm_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_wstore (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_addr),
    .wdata(b_new_w),
    .re   (adv),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  // ---------------- stage B: current weight, write-back, feature product
  always_comb begin
    if (!b_inside) begin
      b_w = '0;                          // outside the store: weight reads as zero
    end else if (fw_valid && fw_addr == b_addr) begin
      b_w = fw_data;                     // previous request just wrote this entry
    end else if (vbit_q) begin
      b_w = ram_rdata;
    end else begin
      b_w = '0;                          // never written since reset
    end

    b_wsum = {b_w[31], b_w} + {b_pcv[31], b_pcv};
    case (b_func)
      FUNC_SET_W: b_new_w = b_pcv;
      FUNC_ADD_W: begin
        if (b_wsum[32] != b_wsum[31]) begin
          b_new_w = b_wsum[32] ? W_MIN : W_MAX;
        end else begin
          b_new_w = b_wsum[31:0];
        end
      end
      default:    b_new_w = b_w;
    endcase

    ram_we = adv && b_valid && b_inside &&
             (b_func == FUNC_SET_W || b_func == FUNC_ADD_W);
    b_feat = b_valid && (b_func == FUNC_FEATURE);
    b_mp   = mprod_t'(b_val) * mprod_t'(b_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid   <= '0;
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= ram_we;
      if (ram_we) begin
        wvalid[b_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr <= b_addr;
      fw_data <= b_new_w;
    end
  end

  // ---------------- stage C: saturating accumulate, hand off on last
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_feat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_last <= b_last;
      c_mp   <= b_mp;
    end
  end

  always_comb begin
    c_sum = {acc[63], acc} + {{17{c_mp[47]}}, c_mp};
    if (c_sum[64] != c_sum[63]) begin
      acc_next = c_sum[64] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_next = c_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid && c_last;
      if (c_valid) begin
        // clear the sum once a vector is complete
        acc <= c_last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sum <= acc_next;
    end
  end

  // ---------------- stage D: score formation
  lsvm_score u_score (
    .sum  (d_sum),
    .bias (bias),
    .score(d_score)
  );

  // ---------------- output register with skid stage
  assign out_take = out_valid && !out_stall;
  assign res_fire = adv && d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;              // skid drains into the output register
      end
    end else if (res_fire) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;              // hold the new score behind the stalled one
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        score <= skid_score;
      end
    end else if (res_fire) begin
      if (!out_valid || out_take) begin
        score <= d_score;
      end else begin
        skid_score <= d_score;
      end
    end
  end

  // ---------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a score while the output register is empty");

  a_write_only_weights: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (b_valid && b_inside && (b_func == FUNC_SET_W || b_func == FUNC_ADD_W)))
    else $error("weight store written by a request that is not a weight update");

  a_fwd_marked_valid: assert property (@(posedge clk) disable iff (rst)
    fw_valid |-> wvalid[fw_addr])
    else $error("forwarded weight belongs to an entry not marked written");

  a_last_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (adv && c_valid && c_last) |=> (d_valid && acc == '0))
    else $error("running sum not cleared or score not handed off after last element");

endmodule

/* bench/tb_linear_svm_decision_engine_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for linear_svm_decision_engine_top: weight build-up and scoring.
// Depends on lsvm_pkg and the engine RTL; holds its own fixed-point scoring predictor.
module tb
  import lsvm_pkg::*;
();

  localparam int FEATURES    = 256;
  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 235;
  localparam int SETTLE      = 8;   // idle cycles before a bias write
  localparam int DRAIN       = 10;  // idle cycles once the last score has come

  // The package names three opcodes; the fourth code does nothing.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef logic signed [15:0] q_t;

  // One row of the directed table. A typed row carries the score that is
  // plain from the arithmetic; the others are left to the predictor.
  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] ix;
    q_t         v;
    q_t         c;
    logic       lst;
    logic       typed;
    score_t     want;
  } vector_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [7:0]  index;
  q_t          value;
  q_t          coefficient;
  logic        last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  score_t      score;
  logic        cfg_we;
  score_t      cfg_data;

  // Predictor state: the hyperplane, the running dot product and the bias.
  weight_t     hyperplane [0:FEATURES-1];
  sum_t        dot_acc;
  score_t      bias_q16;

  score_t      pending_scores [$];
  vector_row_t directed_rows [0:DIR_ROWS-1];
  int unsigned idle_pct  = 37;
  int unsigned stall_pct = 37;
  int unsigned fail_count;
  int unsigned scores_checked;
  int unsigned requests_sent;

  linear_svm_decision_engine_top #(
    .FEATURES (FEATURES)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .index       (index),
    .value       (value),
    .coefficient (coefficient),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .score       (score),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // Advance the predictor by one accepted request; return 1 with the score
  // when the request closes a feature vector.
  function automatic bit svm_predict(input logic [1:0] fn, input logic [7:0] ix,
                                     input q_t v, input q_t c, input logic lst,
                                     output score_t s);
    weight_t             w;
    logic signed [32:0]  wsum;
    logic signed [64:0]  asum;
    logic signed [65:0]  clamped;
    logic signed [65:0]  widened_bias;
    logic signed [65:0]  t;
    localparam logic signed [65:0] SCORE_TOP = 66'sd1 <<< 47;
    s = '0;
    w = hyperplane[ix];
    case (fn)
      FUNC_SET_W: begin
        hyperplane[ix] = v * c;
      end
      FUNC_ADD_W: begin
        wsum = w + v * c;
        if (wsum > W_MAX) hyperplane[ix] = W_MAX;
        else if (wsum < W_MIN) hyperplane[ix] = W_MIN;
        else hyperplane[ix] = wsum[31:0];
      end
      FUNC_FEATURE: begin
        asum = dot_acc + v * w;
        if (asum > SUM_MAX) dot_acc = SUM_MAX;
        else if (asum < SUM_MIN) dot_acc = SUM_MIN;
        else dot_acc = asum[63:0];
        if (lst) begin
          // Clamp the sum, add the widened bias and half an LSB, then floor.
          clamped = dot_acc;
          if (clamped > SUM_LIM) clamped = SUM_LIM;
          if (clamped < -SUM_LIM) clamped = -SUM_LIM;
          widened_bias = bias_q16;
          t = clamped + (widened_bias <<< 16) + 66'sd32768;
          if (t >= SCORE_TOP) s = 32'sh7FFF_FFFF;
          else if (t < -SCORE_TOP) s = 32'sh8000_0000;
          else begin
            t = t >>> 16;
            s = t[31:0];
          end
          dot_acc = '0;
          return 1'b1;
        end
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  // Random fixed-point field: extremes, zero, small magnitudes or any pattern.
  function automatic q_t pick_fixed();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3, 4:    return q_t'($urandom_range(0, 511)) - 16'sd256;
      default: return q_t'($urandom);
    endcase
  endfunction

  // Mostly a small pool of entries, so that writes and reads collide often.
  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  // Send one request: idle at random, then hold the payload until the engine
  // takes it. Record the expected score once the request is accepted.
  task automatic issue(input logic [1:0] fn, input logic [7:0] ix, input q_t v,
                       input q_t c, input logic lst, input bit typed,
                       input score_t want);
    score_t s;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= fn;
    index       <= ix;
    value       <= v;
    coefficient <= c;
    last        <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (svm_predict(fn, ix, v, c, lst, s)) pending_scores.push_back(typed ? want : s);
    requests_sent++;
  endtask

  // Write the bias only with the engine drained: no request in flight and
  // no score outstanding.
  task automatic load_bias(input score_t b);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we   <= 1'b0;
    bias_q16 = b;
  endtask

  // Random traffic for one bias setting. Most of it is well-formed: build
  // an entry from a first support vector plus later ones, or stream a
  // feature vector closed by last. The rest is noise: the unused code,
  // last on weight writes, and feature elements left open.
  task automatic run_phase(input int unsigned quota);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  ix;
    logic [1:0]  fn;
    n = 0;
    while (n < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        ix = pick_index();
        issue(FUNC_SET_W, ix, pick_fixed(), pick_fixed(), 1'($urandom), 1'b0, '0);
        n++;
        repeat ($urandom_range(0, 3)) begin
          issue(FUNC_ADD_W, ix, pick_fixed(), pick_fixed(), 1'($urandom), 1'b0, '0);
          n++;
        end
      end else if (kind < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          issue(FUNC_FEATURE, pick_index(), pick_fixed(), q_t'($urandom),
                k == len - 1, 1'b0, '0);
          n++;
        end
      end else begin
        fn = 2'($urandom);
        issue(fn, 8'($urandom), q_t'($urandom), q_t'($urandom),
              (fn == FUNC_FEATURE) ? 1'b0 : 1'($urandom), 1'b0, '0);
        if (fn != FUNC_UNUSED) n++;
      end
    end
  endtask

  // Stall the result channel at random; the rate drops to zero for one phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every score taken from the engine with the oldest expectation.
  always @(posedge clk) begin
    score_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("score: none expected, actual %0d", score);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (score !== want) begin
          $error("score: expected %0d, actual %0d", want, score);
          fail_count++;
        end
        scores_checked++;
      end
    end
  end

  initial begin
    score_t bias_plan [PHASES];
    // Drive every input before the first edge.
    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = FUNC_SET_W;
    index       = '0;
    value       = '0;
    coefficient = '0;
    last        = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    foreach (hyperplane[i]) hyperplane[i] = '0;
    dot_acc  = '0;
    bias_q16 = '0;

    // Directed table, run with the reset bias of zero.
    directed_rows = '{
      // a fresh entry reads as zero: the score is zero
      '{FUNC_FEATURE, 8'd0,   16'sh7FFF, 16'sh0000, 1'b1, 1'b1, 32'sd0},
      // unused code with last set: nothing comes out
      '{FUNC_UNUSED,  8'd0,   16'shFFFF, 16'shFFFF, 1'b1, 1'b0, 32'sd0},
      // most negative squared, then doubled past the top of the weight range;
      // last on weight writes is ignored
      '{FUNC_SET_W,   8'd0,   16'sh8000, 16'sh8000, 1'b1, 1'b0, 32'sd0},
      '{FUNC_ADD_W,   8'd0,   16'sh8000, 16'sh8000, 1'b1, 1'b0, 32'sd0},
      // top entry driven down to the bottom of the weight range
      '{FUNC_SET_W,   8'd255, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_ADD_W,   8'd255, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_ADD_W,   8'd255, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 32'sd0},
      // three large negative products: score pinned to the minimum
      '{FUNC_FEATURE, 8'd0,   16'sh8000, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd0,   16'sh8000, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd0,   16'sh8000, 16'sh0000, 1'b1, 1'b1, 32'sh8000_0000},
      // three large positive products: score pinned to the maximum
      '{FUNC_FEATURE, 8'd0,   16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd0,   16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd0,   16'sh7FFF, 16'sh0000, 1'b1, 1'b1, 32'sh7FFF_FFFF},
      // two times 2^46 lands exactly on the top bound
      '{FUNC_FEATURE, 8'd255, 16'sh8000, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd255, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 32'sh7FFF_FFFF},
      // 1.0 times 1.0 scores 1.0
      '{FUNC_SET_W,   8'd1,   16'sd4096, 16'sd256,  1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd1,   16'sd4096, 16'sh0000, 1'b1, 1'b1, 32'sd65536},
      // rounding: exactly half rounds up, just below minus half floors to -1
      '{FUNC_SET_W,   8'd3,   16'sd2,    16'sd1,    1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd3,   16'sd16384, 16'sh0000, 1'b1, 1'b1, 32'sd1},
      '{FUNC_FEATURE, 8'd3,  -16'sd16384, 16'sh0000, 1'b1, 1'b1, 32'sd0},
      '{FUNC_FEATURE, 8'd3,  -16'sd16385, 16'sh0000, 1'b1, 1'b1, 32'shFFFF_FFFF},
      // back-to-back hits on one entry: set, add, read
      '{FUNC_SET_W,   8'd4,   16'sd1000, -16'sd77,  1'b0, 1'b0, 32'sd0},
      '{FUNC_ADD_W,   8'd4,  -16'sd5,    16'sd300,  1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd4,   16'sd12345, 16'sh0000, 1'b0, 1'b0, 32'sd0},
      '{FUNC_FEATURE, 8'd255, 16'shFFFF, 16'sh0000, 1'b1, 1'b0, 32'sd0}
    };
    bias_plan = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sh0001_8000,
                  score_t'($urandom), score_t'($urandom_range(0, 131071)) - 32'sd65536};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue(directed_rows[r].fn, directed_rows[r].ix, directed_rows[r].v,
            directed_rows[r].c, directed_rows[r].lst, directed_rows[r].typed,
            directed_rows[r].want);
    end

    // One random phase per bias setting; the zero-bias phase runs with
    // neither side idling.
    for (int p = 0; p < PHASES; p++) begin
      load_bias(bias_plan[p]);
      idle_pct  = (p == 2) ? 0 : 37;
      stall_pct = (p == 2) ? 0 : 37;
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d requests (%0d directed) under %0d bias settings;",
             requests_sent, DIR_ROWS, PHASES + 1);
    $display("%0d scores compared, %0d mismatches.", scores_checked, fail_count);
    if (fail_count == 0 && pending_scores.size() == 0) begin
      $display("[linear_svm_decision_engine_top] OK");
    end else begin
      $display("[linear_svm_decision_engine_top] ERROR");
    end
    $finish;
  end

  // Drop the run if it hangs on a handshake.
  initial begin
    #8_000_000;
    $display("[linear_svm_decision_engine_top] ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/lsvm_pkg.sv
hdl/lsvm_ram.sv
hdl/lsvm_score.sv
hdl/linear_svm_decision_engine_top.sv
bench/tb_linear_svm_decision_engine_top.sv
